// File: rtl/core/scc_pkg.sv
// shared types and constants for the strongly connected component labeler
`default_nettype none
package scc_pkg;

   localparam int STATES = 256;
   localparam int SW     = 8;
   localparam int CW     = 9;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_BUILD = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0]    mode;
      logic [SW-1:0] src_state;
      logic [SW-1:0] dst_state;
      logic [SW-1:0] query_state;
   } cmd_type;

   typedef struct packed {
      logic          edge_added;
      logic [CW-1:0] component_total;
      logic [SW-1:0] state_component;
      logic          state_reached;
      logic          component_live;
   } res_type;

endpackage
`default_nettype wire

// File: rtl/core/scc_ram.sv
// generic single write port memory with registered read
`default_nettype none
module scc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/scc_addr_unit.sv
// shared edge list address unit: state times list length plus edge index
`default_nettype none
module scc_addr_unit
   import scc_pkg::*;
#(
   parameter int EDGES = 20,
   parameter int AW    = $clog2(STATES * EDGES),
   parameter int EW    = $clog2(EDGES + 1)
) (
   input  wire logic [SW-1:0] state_i,
   input  wire logic [EW-1:0] idx_i,
   output logic      [AW-1:0] addr_o
);

   logic [AW-1:0] state_w;

   assign state_w = AW'(state_i);
   assign addr_o  = AW'(state_w * AW'(EDGES)) + AW'(idx_i);

endmodule
`default_nettype wire

// File: rtl/core/scc_ctrl.sv
// sequencer: edge insert, kosaraju walks, reachability and state reads
`default_nettype none
module scc_ctrl
   import scc_pkg::*;
#(
   parameter int EDGES = 20
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [CW-1:0] n_i,
   input  wire logic          cmd_valid_i,
   input  wire cmd_type       cmd_i,
   output logic               ready_o,
   output logic               res_valid_o,
   input  wire logic          res_take_i,
   output res_type            res_o
);

   localparam int AW  = $clog2(STATES * EDGES);
   localparam int EW  = $clog2(EDGES + 1);
   localparam int SKW = EW + SW;

   typedef enum logic [4:0] {
      S_IDLE, S_ADD0, S_ADD1, S_ADD2, S_ADDW, S_ADDP, S_RD0, S_RD1, S_RD2,
      S_CLR, S_WROOT, S_WCNT, S_WSTEP, S_WEDGE, S_WMARK, S_WPOP,
      S_P1SCAN, S_P1CHK, S_VCLR, S_P2SCAN, S_P2GET, S_P2CHK, S_LIVE, S_LCHK, S_RESP
   } state_type;

   typedef enum logic [1:0] {PH_REACH, PH_P1, PH_P2} phase_type;

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic          clr_all_ff, clr_all_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic [CW-1:0] fin_ff, fin_in;
   logic [CW-1:0] comp_ff, comp_in;
   logic [SW-1:0] top_s_ff, top_s_in;
   logic [EW-1:0] top_e_ff, top_e_in;
   logic [EW-1:0] top_cnt_ff, top_cnt_in;
   logic [SW-1:0] tgt_ff, tgt_in;
   logic [EW-1:0] sc_ff, sc_in;
   logic [EW-1:0] pc_ff, pc_in;
   cmd_type       cmd_ff, cmd_in;
   res_type       res_ff, res_in;

   logic          sc_we, pc_we, sm_we, pm_we, lb_we, fo_we, vi_we, rc_we, lv_we, sk_we;
   logic [SW-1:0] sc_wa, pc_wa, lb_wa, fo_wa, vi_wa, rc_wa, lv_wa, sk_wa;
   logic [AW-1:0] sm_wa, pm_wa, sm_ra, pm_ra;
   logic [EW-1:0] sc_wd, pc_wd, sc_rd, pc_rd;
   logic [SW-1:0] sm_wd, pm_wd, sm_rd, pm_rd, lb_wd, lb_rd, fo_wd, fo_rd;
   logic          vi_wd, rc_wd, lv_wd, vi_rd, rc_rd, lv_rd;
   logic [SKW-1:0] sk_wd, sk_rd;
   logic [SW-1:0] sc_ra, pc_ra, lb_ra, fo_ra, vi_ra, rc_ra, lv_ra, sk_ra;
   logic [SW-1:0] au_state;
   logic [EW-1:0] au_idx;
   logic [AW-1:0] au_addr;
   logic [EW-1:0] i_next;
   logic [SW-1:0] edge_t;
   logic          mark_rd;

   scc_addr_unit #(.EDGES(EDGES)) u_addr (
      .state_i(au_state), .idx_i(au_idx), .addr_o(au_addr)
   );

   scc_ram #(.WIDTH(EW), .DEPTH(STATES)) u_succ_cnt (.clock(clock), .wr_en(sc_we),
      .wr_addr(sc_wa), .wr_data(sc_wd), .rd_addr(sc_ra), .rd_data(sc_rd));
   scc_ram #(.WIDTH(EW), .DEPTH(STATES)) u_pred_cnt (.clock(clock), .wr_en(pc_we),
      .wr_addr(pc_wa), .wr_data(pc_wd), .rd_addr(pc_ra), .rd_data(pc_rd));
   scc_ram #(.WIDTH(SW), .DEPTH(STATES * EDGES)) u_succ_mem (.clock(clock), .wr_en(sm_we),
      .wr_addr(sm_wa), .wr_data(sm_wd), .rd_addr(sm_ra), .rd_data(sm_rd));
   scc_ram #(.WIDTH(SW), .DEPTH(STATES * EDGES)) u_pred_mem (.clock(clock), .wr_en(pm_we),
      .wr_addr(pm_wa), .wr_data(pm_wd), .rd_addr(pm_ra), .rd_data(pm_rd));
   scc_ram #(.WIDTH(SW), .DEPTH(STATES)) u_label (.clock(clock), .wr_en(lb_we),
      .wr_addr(lb_wa), .wr_data(lb_wd), .rd_addr(lb_ra), .rd_data(lb_rd));
   scc_ram #(.WIDTH(SW), .DEPTH(STATES)) u_finish (.clock(clock), .wr_en(fo_we),
      .wr_addr(fo_wa), .wr_data(fo_wd), .rd_addr(fo_ra), .rd_data(fo_rd));
   scc_ram #(.WIDTH(1), .DEPTH(STATES)) u_visited (.clock(clock), .wr_en(vi_we),
      .wr_addr(vi_wa), .wr_data(vi_wd), .rd_addr(vi_ra), .rd_data(vi_rd));
   scc_ram #(.WIDTH(1), .DEPTH(STATES)) u_reach (.clock(clock), .wr_en(rc_we),
      .wr_addr(rc_wa), .wr_data(rc_wd), .rd_addr(rc_ra), .rd_data(rc_rd));
   scc_ram #(.WIDTH(1), .DEPTH(STATES)) u_live (.clock(clock), .wr_en(lv_we),
      .wr_addr(lv_wa), .wr_data(lv_wd), .rd_addr(lv_ra), .rd_data(lv_rd));
   scc_ram #(.WIDTH(SKW), .DEPTH(STATES)) u_stack (.clock(clock), .wr_en(sk_we),
      .wr_addr(sk_wa), .wr_data(sk_wd), .rd_addr(sk_ra), .rd_data(sk_rd));

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      clr_all_in = clr_all_ff;
      idx_in     = idx_ff;
      j_in       = j_ff;
      sp_in      = sp_ff;
      fin_in     = fin_ff;
      comp_in    = comp_ff;
      top_s_in   = top_s_ff;
      top_e_in   = top_e_ff;
      top_cnt_in = top_cnt_ff;
      tgt_in     = tgt_ff;
      sc_in      = sc_ff;
      pc_in      = pc_ff;
      cmd_in     = cmd_ff;
      res_in     = res_ff;
      {sc_we, pc_we, sm_we, pm_we, lb_we, fo_we, vi_we, rc_we, lv_we, sk_we} = '0;
      {sc_wa, pc_wa, lb_wa, fo_wa, vi_wa, rc_wa, lv_wa, sk_wa} = '0;
      {sc_ra, pc_ra, lb_ra, fo_ra, vi_ra, rc_ra, lv_ra, sk_ra} = '0;
      sm_wa = '0;
      pm_wa = '0;
      sm_ra = '0;
      pm_ra = '0;
      sc_wd = '0;
      pc_wd = '0;
      sm_wd = '0;
      pm_wd = '0;
      lb_wd = '0;
      fo_wd = '0;
      vi_wd = 1'b0;
      rc_wd = 1'b0;
      lv_wd = 1'b0;
      sk_wd = '0;
      au_state = top_s_ff;
      au_idx   = top_e_ff;
      i_next   = top_e_ff + EW'(1);
      edge_t   = (phase_ff == PH_P1) ? pm_rd : sm_rd;
      mark_rd  = (phase_ff == PH_REACH) ? rc_rd : vi_rd;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid_i) begin
               cmd_in = cmd_i;
               res_in = '0;
               case (cmd_i.mode)
                  MODE_ADD:   state_in = S_ADD0;
                  MODE_BUILD: begin
                     idx_in     = '0;
                     clr_all_in = 1'b0;
                     comp_in    = '0;
                     state_in   = S_CLR;
                  end
                  MODE_READ:  state_in = S_RD0;
                  default:    state_in = S_RESP;
               endcase
            end
         end
         S_ADD0: begin
            sc_ra = cmd_ff.src_state;
            pc_ra = cmd_ff.dst_state;
            if ({1'b0, cmd_ff.src_state} >= n_i || {1'b0, cmd_ff.dst_state} >= n_i) begin
               state_in = S_RESP;
            end else begin
               state_in = S_ADD1;
            end
         end
         S_ADD1: begin
            sc_in    = sc_rd;
            pc_in    = pc_rd;
            top_e_in = '0;
            au_state = cmd_ff.src_state;
            au_idx   = '0;
            sm_ra    = au_addr;
            if (sc_rd >= EW'(EDGES) || pc_rd >= EW'(EDGES)) begin
               state_in = S_RESP;
            end else if (sc_rd == '0) begin
               state_in = S_ADDW;
            end else begin
               state_in = S_ADD2;
            end
         end
         S_ADD2: begin
            au_state = cmd_ff.src_state;
            au_idx   = i_next;
            sm_ra    = au_addr;
            top_e_in = i_next;
            if (sm_rd == cmd_ff.dst_state) begin
               state_in = S_RESP;
            end else if (i_next == sc_ff) begin
               state_in = S_ADDW;
            end
         end
         S_ADDW: begin
            au_state = cmd_ff.src_state;
            au_idx   = sc_ff;
            sm_we    = 1'b1;
            sm_wa    = au_addr;
            sm_wd    = cmd_ff.dst_state;
            sc_we    = 1'b1;
            sc_wa    = cmd_ff.src_state;
            sc_wd    = sc_ff + EW'(1);
            state_in = S_ADDP;
         end
         S_ADDP: begin
            au_state = cmd_ff.dst_state;
            au_idx   = pc_ff;
            pm_we    = 1'b1;
            pm_wa    = au_addr;
            pm_wd    = cmd_ff.src_state;
            pc_we    = 1'b1;
            pc_wa    = cmd_ff.dst_state;
            pc_wd    = pc_ff + EW'(1);
            res_in.edge_added = 1'b1;
            state_in = S_RESP;
         end
         S_RD0: begin
            lb_ra = cmd_ff.query_state;
            rc_ra = cmd_ff.query_state;
            state_in = ({1'b0, cmd_ff.query_state} >= n_i) ? S_RESP : S_RD1;
         end
         S_RD1: begin
            res_in.state_component = lb_rd;
            res_in.state_reached   = rc_rd;
            lv_ra    = lb_rd;
            state_in = S_RD2;
         end
         S_RD2: begin
            res_in.component_live = lv_rd;
            state_in = S_RESP;
         end
         S_CLR: begin
            lb_we = 1'b1;
            lb_wa = idx_ff[SW-1:0];
            rc_we = 1'b1;
            rc_wa = idx_ff[SW-1:0];
            lv_we = 1'b1;
            lv_wa = idx_ff[SW-1:0];
            vi_we = 1'b1;
            vi_wa = idx_ff[SW-1:0];
            sc_we = clr_all_ff;
            sc_wa = idx_ff[SW-1:0];
            pc_we = clr_all_ff;
            pc_wa = idx_ff[SW-1:0];
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(STATES - 1)) begin
               tgt_in   = '0;
               phase_in = PH_REACH;
               if (clr_all_ff) begin
                  clr_all_in = 1'b0;
                  state_in   = S_IDLE;
               end else if (n_i == '0) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_WROOT;
               end
            end
         end
         S_WROOT: begin
            rc_we = (phase_ff == PH_REACH);
            rc_wa = tgt_ff;
            rc_wd = 1'b1;
            vi_we = (phase_ff != PH_REACH);
            vi_wa = tgt_ff;
            vi_wd = 1'b1;
            lb_we = (phase_ff == PH_P2);
            lb_wa = tgt_ff;
            lb_wd = comp_ff[SW-1:0];
            top_s_in = tgt_ff;
            top_e_in = '0;
            sp_in    = CW'(1);
            sc_ra    = tgt_ff;
            pc_ra    = tgt_ff;
            state_in = S_WCNT;
         end
         S_WCNT: begin
            top_cnt_in = (phase_ff == PH_P1) ? pc_rd : sc_rd;
            state_in   = S_WSTEP;
         end
         S_WSTEP: begin
            sm_ra = au_addr;
            pm_ra = au_addr;
            sk_ra = 8'(sp_ff - CW'(2));
            if (top_e_ff < top_cnt_ff) begin
               top_e_in = i_next;
               state_in = S_WEDGE;
            end else begin
               fo_we = (phase_ff == PH_P1);
               fo_wa = fin_ff[SW-1:0];
               fo_wd = top_s_ff;
               if (phase_ff == PH_P1) begin
                  fin_in = fin_ff + CW'(1);
               end
               sp_in = sp_ff - CW'(1);
               if (sp_ff == CW'(1)) begin
                  case (phase_ff)
                     PH_REACH: begin
                        phase_in = PH_P1;
                        idx_in   = '0;
                        fin_in   = '0;
                     end
                     PH_P2:    comp_in = comp_ff + CW'(1);
                     default:  ;
                  endcase
                  state_in = (phase_ff == PH_P2) ? S_P2SCAN : S_P1SCAN;
               end else begin
                  state_in = S_WPOP;
               end
            end
         end
         S_WEDGE: begin
            tgt_in = edge_t;
            vi_ra  = edge_t;
            rc_ra  = edge_t;
            state_in = ({1'b0, edge_t} < n_i) ? S_WMARK : S_WSTEP;
         end
         S_WMARK: begin
            sc_ra = tgt_ff;
            pc_ra = tgt_ff;
            if (!mark_rd && sp_ff < CW'(STATES)) begin
               rc_we = (phase_ff == PH_REACH);
               rc_wa = tgt_ff;
               rc_wd = 1'b1;
               vi_we = (phase_ff != PH_REACH);
               vi_wa = tgt_ff;
               vi_wd = 1'b1;
               lb_we = (phase_ff == PH_P2);
               lb_wa = tgt_ff;
               lb_wd = comp_ff[SW-1:0];
               sk_we = 1'b1;
               sk_wa = 8'(sp_ff - CW'(1));
               sk_wd = {top_e_ff, top_s_ff};
               top_s_in = tgt_ff;
               top_e_in = '0;
               sp_in    = sp_ff + CW'(1);
               state_in = S_WCNT;
            end else begin
               state_in = S_WSTEP;
            end
         end
         S_WPOP: begin
            top_s_in = sk_rd[SW-1:0];
            top_e_in = sk_rd[SKW-1:SW];
            sc_ra    = sk_rd[SW-1:0];
            pc_ra    = sk_rd[SW-1:0];
            state_in = S_WCNT;
         end
         S_P1SCAN: begin
            vi_ra = idx_ff[SW-1:0];
            if (idx_ff == n_i) begin
               idx_in   = '0;
               state_in = S_VCLR;
            end else begin
               state_in = S_P1CHK;
            end
         end
         S_P1CHK: begin
            idx_in   = idx_ff + CW'(1);
            tgt_in   = idx_ff[SW-1:0];
            state_in = vi_rd ? S_P1SCAN : S_WROOT;
         end
         S_VCLR: begin
            vi_we  = 1'b1;
            vi_wa  = idx_ff[SW-1:0];
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(STATES - 1)) begin
               phase_in = PH_P2;
               j_in     = fin_ff;
               state_in = S_P2SCAN;
            end
         end
         S_P2SCAN: begin
            fo_ra = 8'(j_ff - CW'(1));
            if (j_ff == '0) begin
               idx_in   = '0;
               state_in = S_LIVE;
            end else begin
               j_in     = j_ff - CW'(1);
               state_in = S_P2GET;
            end
         end
         S_P2GET: begin
            tgt_in   = fo_rd;
            vi_ra    = fo_rd;
            state_in = S_P2CHK;
         end
         S_P2CHK: begin
            state_in = vi_rd ? S_P2SCAN : S_WROOT;
         end
         S_LIVE: begin
            rc_ra = idx_ff[SW-1:0];
            sc_ra = idx_ff[SW-1:0];
            lb_ra = idx_ff[SW-1:0];
            state_in = (idx_ff == n_i) ? S_RESP : S_LCHK;
         end
         S_LCHK: begin
            lv_we    = rc_rd && (sc_rd != '0);
            lv_wa    = lb_rd;
            lv_wd    = 1'b1;
            idx_in   = idx_ff + CW'(1);
            state_in = S_LIVE;
         end
         S_RESP: begin
            if (res_take_i) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         phase_ff   <= PH_REACH;
         clr_all_ff <= 1'b1;
         idx_ff     <= '0;
         sp_ff      <= '0;
         fin_ff     <= '0;
         comp_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         clr_all_ff <= clr_all_in;
         idx_ff     <= idx_in;
         sp_ff      <= sp_in;
         fin_ff     <= fin_in;
         comp_ff    <= comp_in;
      end
      j_ff       <= j_in;
      top_s_ff   <= top_s_in;
      top_e_ff   <= top_e_in;
      top_cnt_ff <= top_cnt_in;
      tgt_ff     <= tgt_in;
      sc_ff      <= sc_in;
      pc_ff      <= pc_in;
      cmd_ff     <= cmd_in;
      res_ff     <= res_in;
   end

   always_comb begin
      res_o = res_ff;
      res_o.component_total = comp_ff;
   end

   assign ready_o     = (state_ff == S_IDLE);
   assign res_valid_o = (state_ff == S_RESP);

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CW'(STATES)) else $error("walk stack overflow");
   a_comp_fin: assert property (@(posedge clock) disable iff (reset)
      comp_ff <= fin_ff) else $error("more components than finished states");
   a_step_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WSTEP |-> sp_ff != '0) else $error("walk step on empty stack");

endmodule
`default_nettype wire

// File: rtl/core/transition_graph_scc_labeler.sv
// top level: stream ports, size register and response register
// One word at a time: the next word is taken in the cycle after the response
// leaves the sequencer. Add-edge scans the stored successors for duplicates
// before storing. A build runs a clearing sweep over all 256 states, a
// depth-first walk from state 0, a reverse graph walk, a visited sweep over
// all 256 states, a forward walk and a live pass, all on one edge address
// unit and memories with one write port and one read port each. After reset
// a clearing pass over all 256 states runs before the first word is taken.
`default_nettype none
module transition_graph_scc_labeler
   import scc_pkg::*;
#(
   parameter int MAX_EDGES_PER_STATE = 20
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wen,
   input  wire logic [CW-1:0] csr_wdata,   // num_states
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [23:0]   req_tdata,   // src_state, dst_state, query_state
   input  wire logic [1:0]    req_tuser,   // mode
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [23:0]        rsp_tdata    // edge_added, component_total,
                                           // state_component, state_reached,
                                           // component_live, zero pad
);

   logic [CW-1:0] num_ff, num_in;
   logic [CW-1:0] n_w;
   logic          rsp_valid_ff, rsp_valid_in;
   res_type       rsp_ff, rsp_in;
   cmd_type       cmd_w;
   res_type       res_w;
   logic          res_valid_w, res_take_w, ready_w;

   assign n_w = (num_ff > CW'(STATES)) ? CW'(STATES) : num_ff;

   assign cmd_w.mode        = req_tuser;
   assign cmd_w.src_state   = req_tdata[7:0];
   assign cmd_w.dst_state   = req_tdata[15:8];
   assign cmd_w.query_state = req_tdata[23:16];

   scc_ctrl #(.EDGES(MAX_EDGES_PER_STATE)) u_ctrl (
      .clock(clock), .reset(reset), .n_i(n_w),
      .cmd_valid_i(req_tvalid), .cmd_i(cmd_w), .ready_o(ready_w),
      .res_valid_o(res_valid_w), .res_take_i(res_take_w), .res_o(res_w)
   );

   assign res_take_w = res_valid_w && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      num_in       = csr_wen ? csr_wdata : num_ff;
      rsp_valid_in = res_take_w || (rsp_valid_ff && !rsp_tready);
      rsp_in       = res_take_w ? res_w : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= CW'(STATES);
         rsp_valid_ff <= 1'b0;
      end else begin
         num_ff       <= num_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign req_tready = ready_w;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.component_live, rsp_ff.state_reached,
                        rsp_ff.state_component, rsp_ff.component_total,
                        rsp_ff.edge_added};

endmodule
`default_nettype wire
